[rtl/row_sorted_matrix_median_unit_macros.svh]
// Assertion macros shared by the median unit RTL.
// Define ASSERT_OFF to drop every check.
`ifndef ROW_SORTED_MATRIX_MEDIAN_UNIT_MACROS_SVH
`define ROW_SORTED_MATRIX_MEDIAN_UNIT_MACROS_SVH

`ifndef ASSERT_OFF

`define RSMM_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

`define RSMM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`else

`define RSMM_ASSERT(lbl, prop, msg)

`define RSMM_ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

[rtl/rsmm_pkg.sv]
// Shared constants for the row-sorted matrix median unit.
// No dependencies.
package rsmm_pkg;

  localparam int VALUE_W   = 30;
  localparam int DIM_W     = 6;
  localparam int REG_IDX_W = 2;

  localparam logic [VALUE_W-1:0] VALUE_MIN = 30'd1;
  localparam logic [VALUE_W-1:0] VALUE_MAX = 30'd1000000000;

  localparam logic [REG_IDX_W-1:0] REG_ROW_COUNT = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_COL_COUNT = 2'd1;

endpackage

[rtl/row_sorted_matrix_median_unit.sv]
// Top level of the row-sorted matrix median unit: load counter, element store, result register.
// Depends on rsmm_pkg, rsmm_ram, rsmm_search and the macro header.
//
//   channel   direction  handshake            payload
//   in_       input      in_valid / in_stall  in_element_value
//   out_      output     out_valid/out_stall  out_median_value
//   cfg_      input      cfg_we               cfg_index, cfg_wdata
//
// Load: one element word per cycle into the store while no search is running.
// Search: run time is set by the single compare unit and the registered store read behind each
// probe; input stalls meanwhile.
// The result register frees the search as soon as the result is parked; loading resumes then.
// Reset (synchronous, active low) clears the load count and sets both dimensions to one.
`include "row_sorted_matrix_median_unit_macros.svh"

module row_sorted_matrix_median_unit
  import rsmm_pkg::*;
#(
  parameter int MAX_ROWS = 32,
  parameter int MAX_COLS = 32
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [VALUE_W-1:0]   in_element_value,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [VALUE_W-1:0]   out_median_value,
  input  logic                 cfg_we,
  input  logic [REG_IDX_W-1:0] cfg_index,
  input  logic [DIM_W-1:0]     cfg_wdata
);

  localparam int DEPTH = MAX_ROWS * MAX_COLS;
  localparam int RW    = $clog2(MAX_ROWS + 1);
  localparam int CLW   = $clog2(MAX_COLS + 1);
  localparam int CW    = $clog2(DEPTH + 1);
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [DIM_W-1:0]   row_count_r, row_count_nxt, col_count_r, col_count_nxt;
  logic [CW-1:0]      loaded_count_r, loaded_count_nxt, loaded_inc;
  logic               out_valid_r, out_valid_nxt;
  logic [VALUE_W-1:0] out_value_r, out_value_nxt;
  logic [RW-1:0]      rows_eff;
  logic [CLW-1:0]     cols_eff;
  logic [CW-1:0]      total;
  logic [VALUE_W-1:0] sat_value;
  logic               in_accept, matrix_full, out_free;
  logic               search_busy, search_done;
  logic [VALUE_W-1:0] search_result, rd_data;
  logic [AW-1:0]      rd_addr;

  always_comb begin
    if (row_count_r == '0) begin
      rows_eff = RW'(1);
    end else if (32'(row_count_r) > MAX_ROWS) begin
      rows_eff = RW'(MAX_ROWS);
    end else begin
      rows_eff = RW'(row_count_r);
    end
    if (col_count_r == '0) begin
      cols_eff = CLW'(1);
    end else if (32'(col_count_r) > MAX_COLS) begin
      cols_eff = CLW'(MAX_COLS);
    end else begin
      cols_eff = CLW'(col_count_r);
    end
  end

  assign total = CW'(rows_eff) * CW'(cols_eff);

  always_comb begin
    if (in_element_value < VALUE_MIN) begin
      sat_value = VALUE_MIN;
    end else if (in_element_value > VALUE_MAX) begin
      sat_value = VALUE_MAX;
    end else begin
      sat_value = in_element_value;
    end
  end

  assign in_stall    = search_busy;
  assign in_accept   = in_valid && !search_busy;
  assign loaded_inc  = loaded_count_r + 1'b1;
  assign matrix_full = in_accept && (loaded_inc >= total);
  assign out_free    = !out_valid_r || !out_stall;

  always_comb begin
    row_count_nxt    = row_count_r;
    col_count_nxt    = col_count_r;
    loaded_count_nxt = loaded_count_r;
    out_valid_nxt    = out_valid_r;
    out_value_nxt    = out_value_r;
    if (in_accept) begin
      loaded_count_nxt = matrix_full ? '0 : loaded_inc;
    end
    if (cfg_we) begin
      case (cfg_index)
        REG_ROW_COUNT: begin
          row_count_nxt    = cfg_wdata;
          loaded_count_nxt = '0;
        end
        REG_COL_COUNT: begin
          col_count_nxt    = cfg_wdata;
          loaded_count_nxt = '0;
        end
        default: ;
      endcase
    end
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
    if (search_done && out_free) begin
      out_valid_nxt = 1'b1;
      out_value_nxt = search_result;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_count_r    <= DIM_W'(1);
      col_count_r    <= DIM_W'(1);
      loaded_count_r <= '0;
      out_valid_r    <= 1'b0;
    end else begin
      row_count_r    <= row_count_nxt;
      col_count_r    <= col_count_nxt;
      loaded_count_r <= loaded_count_nxt;
      out_valid_r    <= out_valid_nxt;
    end
    out_value_r <= out_value_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_median_value = out_value_r;

  rsmm_ram #(
    .WIDTH (VALUE_W),
    .DEPTH (DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (in_accept),
    .waddr (loaded_count_r[AW-1:0]),
    .wdata (sat_value),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  rsmm_search #(
    .MAX_ROWS (MAX_ROWS),
    .MAX_COLS (MAX_COLS)
  ) u_search (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (matrix_full),
    .rows    (rows_eff),
    .cols    (cols_eff),
    .half    (total >> 1),
    .ack     (out_free),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .busy    (search_busy),
    .done    (search_done),
    .result  (search_result)
  );

  `RSMM_ASSERT(a_load_below_total, loaded_count_r < total, "load count at or past matrix size")
  `RSMM_ASSERT_NEXT(a_start_busy, matrix_full, search_busy, "search not running after full matrix")
  `RSMM_ASSERT_NEXT(a_result_parked, search_done && out_free, out_valid_r, "finished result not registered")
  `RSMM_ASSERT_NEXT(a_result_waits, search_done && !out_free, search_done, "pending result dropped")

endmodule

[rtl/rsmm_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module rsmm_ram #(
  parameter int WIDTH = 30,
  parameter int DEPTH = 1024
) (
  input  logic                                    clk,
  input  logic                                    we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                        wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                        rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata <= mem_r[raddr];
  end

endmodule

[rtl/rsmm_search.sv]
// Iterative median search: outer value bisection, per-row bisection over the store.
// One compare unit reused for every probe. Depends on rsmm_pkg and the macro header.
`include "row_sorted_matrix_median_unit_macros.svh"

module rsmm_search
  import rsmm_pkg::*;
#(
  parameter int MAX_ROWS = 32,
  parameter int MAX_COLS = 32
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  logic [$clog2(MAX_ROWS+1)-1:0] rows,
  input  logic [$clog2(MAX_COLS+1)-1:0] cols,
  input  logic [$clog2(MAX_ROWS*MAX_COLS+1)-1:0] half,
  input  logic                      ack,
  output logic [((MAX_ROWS*MAX_COLS > 1) ? $clog2(MAX_ROWS*MAX_COLS) : 1)-1:0] rd_addr,
  input  logic [VALUE_W-1:0]        rd_data,
  output logic                      busy,
  output logic                      done,
  output logic [VALUE_W-1:0]        result
);

  localparam int DEPTH = MAX_ROWS * MAX_COLS;
  localparam int RW    = $clog2(MAX_ROWS + 1);
  localparam int CLW   = $clog2(MAX_COLS + 1);
  localparam int CW    = $clog2(DEPTH + 1);
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  typedef enum logic [2:0] {
    S_IDLE, S_CAND, S_ROW, S_PROBE, S_CMP, S_DEC, S_DONE
  } state_t;

  state_t               state_r, state_nxt;
  logic [RW-1:0]        rows_r, rows_nxt, row_r, row_nxt;
  logic [CLW-1:0]       cols_r, cols_nxt;
  logic [CW-1:0]        half_r, half_nxt, cnt_r, cnt_nxt, base_r, base_nxt;
  logic [VALUE_W-1:0]   lo_r, lo_nxt, hi_r, hi_nxt, mid_r, mid_nxt;
  logic [CLW-1:0]       ilo_r, ilo_nxt, ihi_r, ihi_nxt, imid_r, imid_nxt;
  logic [CLW:0]         isum;
  logic [CLW-1:0]       imid;
  logic [VALUE_W:0]     osum;

  assign isum    = {1'b0, ilo_r} + {1'b0, ihi_r} - {{CLW{1'b0}}, 1'b1};
  assign imid    = isum[CLW:1];
  assign osum    = {1'b0, lo_r} + {1'b0, hi_r};
  assign rd_addr = AW'(base_r + CW'(imid));
  assign busy    = (state_r != S_IDLE);
  assign done    = (state_r == S_DONE);
  assign result  = lo_r;

  always_comb begin
    state_nxt = state_r;
    rows_nxt  = rows_r;
    cols_nxt  = cols_r;
    half_nxt  = half_r;
    lo_nxt    = lo_r;
    hi_nxt    = hi_r;
    mid_nxt   = mid_r;
    cnt_nxt   = cnt_r;
    base_nxt  = base_r;
    row_nxt   = row_r;
    ilo_nxt   = ilo_r;
    ihi_nxt   = ihi_r;
    imid_nxt  = imid_r;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          rows_nxt  = rows;
          cols_nxt  = cols;
          half_nxt  = half;
          lo_nxt    = VALUE_MIN;
          hi_nxt    = VALUE_MAX;
          state_nxt = S_CAND;
        end
      end
      S_CAND: begin
        if (lo_r <= hi_r) begin
          mid_nxt   = osum[VALUE_W:1];
          cnt_nxt   = '0;
          base_nxt  = '0;
          row_nxt   = '0;
          state_nxt = S_ROW;
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_ROW: begin
        if (row_r == rows_r) begin
          state_nxt = S_DEC;
        end else begin
          ilo_nxt   = '0;
          ihi_nxt   = cols_r;
          state_nxt = S_PROBE;
        end
      end
      S_PROBE: begin
        if (ilo_r < ihi_r) begin
          imid_nxt  = imid;
          state_nxt = S_CMP;
        end else begin
          cnt_nxt   = cnt_r + CW'(ilo_r);
          base_nxt  = base_r + CW'(cols_r);
          row_nxt   = row_r + 1'b1;
          state_nxt = S_ROW;
        end
      end
      S_CMP: begin
        if (rd_data <= mid_r) begin
          ilo_nxt = imid_r + 1'b1;
        end else begin
          ihi_nxt = imid_r;
        end
        state_nxt = S_PROBE;
      end
      S_DEC: begin
        if (cnt_r <= half_r) begin
          lo_nxt = mid_r + 1'b1;
        end else begin
          hi_nxt = mid_r - 1'b1;
        end
        state_nxt = S_CAND;
      end
      S_DONE: begin
        if (ack) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
    rows_r <= rows_nxt;
    cols_r <= cols_nxt;
    half_r <= half_nxt;
    lo_r   <= lo_nxt;
    hi_r   <= hi_nxt;
    mid_r  <= mid_nxt;
    cnt_r  <= cnt_nxt;
    base_r <= base_nxt;
    row_r  <= row_nxt;
    ilo_r  <= ilo_nxt;
    ihi_r  <= ihi_nxt;
    imid_r <= imid_nxt;
  end

  `RSMM_ASSERT(a_cmp_after_probe, (state_r != S_CMP) || ($past(state_r) == S_PROBE), "compare without a read")
  `RSMM_ASSERT(a_cmp_window, (state_r != S_CMP) || (ilo_r < ihi_r), "row window empty at compare")
  `RSMM_ASSERT(a_lo_floor, (state_r == S_IDLE) || (lo_r >= VALUE_MIN), "candidate low bound below one")
  `RSMM_ASSERT(a_result_range, !done || (result <= VALUE_MAX), "median out of range")

endmodule
